// ===== design/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg
// shared types and constants of the windowed repetition penalty block
// ----------------------------------------------------------------------------
`default_nettype none
package wrp_pkg;

	localparam logic [2:0] CFG_WINDOW_LENGTH    = 3'd0;
	localparam logic [2:0] CFG_VOCAB_IN_USE     = 3'd1;
	localparam logic [2:0] CFG_REPEAT_FACTOR    = 3'd2;
	localparam logic [2:0] CFG_PRESENCE_AMOUNT  = 3'd3;
	localparam logic [2:0] CFG_FREQUENCY_AMOUNT = 3'd4;

	localparam logic       KIND_UPDATE = 1'b0;
	localparam logic       KIND_ADJUST = 1'b1;

	localparam logic [15:0] ONE_Q12 = 16'd4096;

	typedef struct packed {
		logic               kind;
		logic [1:0]         stream;
		logic [11:0]        token;
		logic               end_of_step;
		logic signed [15:0] logit_in;
		logic               bad;
	} item_t;

	typedef struct packed {
		logic [8:0]         window_length;
		logic [15:0]        repeat_factor;
		logic signed [15:0] presence_amount;
		logic signed [15:0] frequency_amount;
	} cfg_t;

endpackage
`default_nettype wire

// ===== design/wrp_front.sv =====
// ----------------------------------------------------------------------------
// wrp_front
// input side: takes beats and flags rejected tokens and streams
// ----------------------------------------------------------------------------
`default_nettype none
module wrp_front import wrp_pkg::*; #(
	parameter int BATCH = 4,
	parameter int VOCAB = 4096
) (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [1:0]         stream,
	input  wire logic [11:0]        token,
	input  wire logic               end_of_step,
	input  wire logic signed [15:0] logit_in,
	input  wire logic [12:0]        vocab_in_use,
	input  wire logic               clearing,
	input  wire logic               q_ready,
	output logic                    q_push,
	output item_t                   q_item
);

	logic tok_ok;
	logic str_ok;

	assign tok_ok   = (32'(token) < 32'(vocab_in_use)) && (32'(token) < VOCAB);
	assign str_ok   = 32'(stream) < BATCH;
	assign in_ready = q_ready && !clearing;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_item.kind        = kind;
		q_item.stream      = stream;
		q_item.token       = token;
		q_item.end_of_step = end_of_step;
		q_item.logit_in    = logit_in;
		q_item.bad         = !(tok_ok && str_ok);
	end

endmodule
`default_nettype wire

// ===== design/wrp_queue.sv =====
// ----------------------------------------------------------------------------
// wrp_queue
// two-entry queue between the input side and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module wrp_queue import wrp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       ready,
	input  wire logic  pop,
	output logic       head_valid,
	output item_t      head
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign ready      = cnt_q != 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// ===== design/wrp_back.sv =====
// ----------------------------------------------------------------------------
// wrp_back
// sequencer: count and history stores, divider and penalty arithmetic
// ----------------------------------------------------------------------------
`default_nettype none
module wrp_back import wrp_pkg::*; #(
	parameter int BATCH      = 4,
	parameter int VOCAB      = 4096,
	parameter int WINDOW_MAX = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               head_valid,
	input  wire item_t              head,
	output logic                    pop,
	output logic                    clearing,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      logit_out,
	output logic                    status
);

	localparam int SW   = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam int VW   = (VOCAB > 1) ? $clog2(VOCAB) : 1;
	localparam int HW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WNW  = $clog2(WINDOW_MAX + 1);
	localparam int WN1  = WNW + 1;
	localparam int CAW  = SW + VW;
	localparam int HAW  = SW + HW;
	localparam int CLW  = (CAW > HAW) ? CAW : HAW;
	localparam int CNT_DEPTH  = 1 << CAW;
	localparam int HIST_DEPTH = 1 << HAW;
	localparam int SWEEP      = (CNT_DEPTH > HIST_DEPTH) ? CNT_DEPTH : HIST_DEPTH;
	localparam int CB   = COUNT_BITS;
	localparam int VWID = CB + 19;
	localparam logic [CB-1:0] COUNT_MAX = '1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOOK = 4'd1;
	localparam logic [3:0] S_ORD  = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_SCL  = 4'd6;
	localparam logic [3:0] S_ADD  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	localparam logic [1:0] M_PASS = 2'd0;
	localparam logic [1:0] M_DIV  = 2'd1;
	localparam logic [1:0] M_MUL  = 2'd2;

	logic [CB-1:0]  cnt_mem  [CNT_DEPTH];
	logic [12:0]    hist_mem [HIST_DEPTH];

	logic [3:0]     state_q;
	item_t          item_q;
	logic [CB-1:0]  cnt_rd_q;
	logic [12:0]    hist_rd_q;
	logic [HW-1:0]  slot_q;
	logic [11:0]    old_q;
	logic [CB-1:0]  count_q;
	logic [1:0]     mode_q;
	logic [17:0]    rem_q;
	logic [15:0]    num_q;
	logic [15:0]    quot_q;
	logic [3:0]     iter_q;
	logic [31:0]    prod_q;
	logic signed [CB+16:0] cf_q;
	logic signed [21:0]    scaled_q;
	logic signed [15:0]    res_logit_q;
	logic           res_status_q;
	logic           out_valid_q;
	logic signed [15:0]    out_logit_q;
	logic           out_status_q;
	logic           clr_busy_q;
	logic [CLW-1:0] clr_idx_q;

	// index formation
	logic [SW+1:0]  head_st_ext;
	logic [VW+11:0] head_tok_ext;
	logic [SW+1:0]  item_st_ext;
	logic [VW+11:0] item_tok_ext;
	logic [VW+11:0] old_tok_ext;
	logic [CAW-1:0] head_caddr;
	logic [CAW-1:0] item_caddr;
	logic [CAW-1:0] old_caddr;
	logic [HAW-1:0] head_haddr;
	logic [HAW-1:0] item_haddr;

	assign head_st_ext  = {{SW{1'b0}}, head.stream};
	assign head_tok_ext = {{VW{1'b0}}, head.token};
	assign item_st_ext  = {{SW{1'b0}}, item_q.stream};
	assign item_tok_ext = {{VW{1'b0}}, item_q.token};
	assign old_tok_ext  = {{VW{1'b0}}, old_q};
	assign head_caddr   = {head_st_ext[SW-1:0], head_tok_ext[VW-1:0]};
	assign item_caddr   = {item_st_ext[SW-1:0], item_tok_ext[VW-1:0]};
	assign old_caddr    = {item_st_ext[SW-1:0], old_tok_ext[VW-1:0]};

	// window and slot
	logic [31:0]    wl32;
	logic [WNW-1:0] win;
	logic [HW-1:0]  slot_cur;
	logic [WN1-1:0] slot_inc;
	logic [HW-1:0]  slot_next;

	assign wl32      = 32'(cfg.window_length);
	assign win       = (wl32 > WINDOW_MAX) ? WNW'(WINDOW_MAX) : wl32[WNW-1:0];
	assign slot_cur  = (WNW'(slot_q) < win) ? slot_q : '0;
	assign slot_inc  = WN1'(slot_cur) + WN1'(1);
	assign slot_next = (slot_inc >= WN1'(win)) ? '0 : slot_inc[HW-1:0];
	assign head_haddr = {head_st_ext[SW-1:0], slot_cur};
	assign item_haddr = {item_st_ext[SW-1:0], slot_cur};

	// arithmetic
	logic               pen_on;
	logic signed [16:0] xs;
	logic [16:0]        mag;
	logic [28:0]        num;
	logic [16:0]        den;
	logic [17:0]        rem_sh;
	logic [31:0]        prod_rnd;
	logic signed [VWID-1:0] v;

	assign pen_on   = cfg.repeat_factor > ONE_Q12;
	assign xs       = 17'(item_q.logit_in);
	assign mag      = 17'(-xs);
	assign num      = {1'b0, item_q.logit_in[14:0], 13'b0} + 29'(cfg.repeat_factor);
	assign den      = {cfg.repeat_factor, 1'b0};
	assign rem_sh   = {rem_q[16:0], num_q[15]};
	assign prod_rnd = prod_q + 32'd2048;
	assign v        = VWID'(scaled_q) - VWID'(cfg.presence_amount) - VWID'(cf_q);

	// store ports
	logic           cnt_we;
	logic [CAW-1:0] cnt_waddr;
	logic [CB-1:0]  cnt_wdata;
	logic [CAW-1:0] cnt_raddr;
	logic           hist_we;
	logic [HAW-1:0] hist_waddr;
	logic [12:0]    hist_wdata;
	logic           upd_look;

	assign upd_look  = (state_q == S_LOOK) && (item_q.kind == KIND_UPDATE) && !item_q.bad;
	assign cnt_raddr = (state_q == S_ORD) ? old_caddr : head_caddr;

	always_comb begin
		cnt_we     = 1'b0;
		cnt_waddr  = item_caddr;
		cnt_wdata  = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + CB'(1);
		hist_we    = 1'b0;
		hist_waddr = item_haddr;
		hist_wdata = {1'b1, item_q.token};
		if (clr_busy_q) begin
			cnt_we     = 32'(clr_idx_q) < CNT_DEPTH;
			cnt_waddr  = clr_idx_q[CAW-1:0];
			cnt_wdata  = '0;
			hist_we    = 32'(clr_idx_q) < HIST_DEPTH;
			hist_waddr = clr_idx_q[HAW-1:0];
			hist_wdata = '0;
		end else if (upd_look) begin
			cnt_we  = 1'b1;
			hist_we = win != '0;
		end else if (state_q == S_DEC) begin
			cnt_we    = cnt_rd_q != '0;
			cnt_waddr = old_caddr;
			cnt_wdata = cnt_rd_q - CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rd_q <= hist_mem[head_haddr];
	end

	assign clearing  = clr_busy_q;
	assign pop       = (state_q == S_IDLE) && head_valid && !clr_busy_q;
	assign out_valid = out_valid_q;
	assign logit_out = out_logit_q;
	assign status    = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + CLW'(1);
			if (clr_idx_q == CLW'(SWEEP - 1)) clr_busy_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) item_q <= head;
		unique case (state_q)
			S_LOOK: begin
				count_q <= cnt_rd_q;
				old_q   <= hist_rd_q[11:0];
				rem_q   <= 18'(num[28:16]);
				num_q   <= num[15:0];
				quot_q  <= '0;
				iter_q  <= '0;
				if (!pen_on) mode_q <= M_PASS;
				else if (!item_q.logit_in[15] && item_q.logit_in != '0) mode_q <= M_DIV;
				else mode_q <= M_MUL;
				if (item_q.kind == KIND_ADJUST) begin
					res_logit_q <= item_q.logit_in;
				end else begin
					res_logit_q <= '0;
				end
				res_status_q <= item_q.bad;
			end
			S_DIV: begin
				if (rem_sh >= 18'(den)) begin
					rem_q  <= rem_sh - 18'(den);
					quot_q <= {quot_q[14:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					quot_q <= {quot_q[14:0], 1'b0};
				end
				num_q  <= {num_q[14:0], 1'b0};
				iter_q <= iter_q + 4'd1;
			end
			S_MUL: begin
				prod_q <= 32'(mag) * 32'(cfg.repeat_factor);
				cf_q   <= $signed({1'b0, count_q}) * cfg.frequency_amount;
			end
			S_SCL: begin
				unique case (mode_q)
					M_DIV:   scaled_q <= 22'($signed({1'b0, quot_q}));
					M_MUL:   scaled_q <= -22'($signed({1'b0, prod_rnd[31:12]}));
					default: scaled_q <= 22'(item_q.logit_in);
				endcase
			end
			S_ADD: begin
				if (v > VWID'(32767)) res_logit_q <= 16'sh7fff;
				else if (v < VWID'(-32768)) res_logit_q <= -16'sh8000;
				else res_logit_q <= v[15:0];
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && !out_valid_q) begin
			out_logit_q  <= res_logit_q;
			out_status_q <= res_status_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (item_q.bad) begin
						state_q <= S_DONE;
					end else if (item_q.kind == KIND_ADJUST) begin
						if (cnt_rd_q == '0) state_q <= S_DONE;
						else if (pen_on && !item_q.logit_in[15] && item_q.logit_in != '0)
							state_q <= S_DIV;
						else state_q <= S_MUL;
					end else if (win != '0) begin
						slot_q  <= item_q.end_of_step ? slot_next : slot_cur;
						state_q <= hist_rd_q[12] ? S_ORD : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ORD: state_q <= S_DEC;
				S_DEC: state_q <= S_DONE;
				S_DIV: begin
					if (iter_q == 4'd15) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_SCL;
				S_SCL: state_q <= S_ADD;
				S_ADD: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop) else $error("item taken during clearing");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |=> (state_q == S_DIV || state_q == S_MUL))
		else $error("divider left early");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done");
`endif

endmodule
`default_nettype wire

// ===== design/windowed_repetition_penalty.sv =====
// ----------------------------------------------------------------------------
// windowed_repetition_penalty
// per-stream windowed token counts with repetition, presence and frequency
// penalty on Q8.8 logits
// ----------------------------------------------------------------------------
// throughput: one item at a time through the sequencer; the 16-step
// divider sets the worst case
// reset: asynchronous; after reset a clearing pass that zeroes the count and
// history stores runs before items are taken
// ----------------------------------------------------------------------------
`default_nettype none
module windowed_repetition_penalty import wrp_pkg::*; #(
	parameter int BATCH      = 4,
	parameter int VOCAB      = 4096,
	parameter int WINDOW_MAX = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [1:0]         stream,
	input  wire logic [11:0]        token,
	input  wire logic               end_of_step,
	input  wire logic signed [15:0] logit_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      logit_out,
	output logic                    status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	cfg_t        cfg_q;
	logic [12:0] vocab_in_use_q;
	logic        clearing;
	logic        q_ready;
	logic        q_push;
	item_t       q_item;
	logic        pop;
	logic        head_valid;
	item_t       head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length    <= '0;
			vocab_in_use_q         <= 13'd4096;
			cfg_q.repeat_factor    <= ONE_Q12;
			cfg_q.presence_amount  <= '0;
			cfg_q.frequency_amount <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_LENGTH:    cfg_q.window_length    <= cfg_data[8:0];
				CFG_VOCAB_IN_USE:     vocab_in_use_q         <= cfg_data[12:0];
				CFG_REPEAT_FACTOR:    cfg_q.repeat_factor    <= cfg_data;
				CFG_PRESENCE_AMOUNT:  cfg_q.presence_amount  <= cfg_data;
				CFG_FREQUENCY_AMOUNT: cfg_q.frequency_amount <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wrp_front #(.BATCH(BATCH), .VOCAB(VOCAB)) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.stream       (stream),
		.token        (token),
		.end_of_step  (end_of_step),
		.logit_in     (logit_in),
		.vocab_in_use (vocab_in_use_q),
		.clearing     (clearing),
		.q_ready      (q_ready),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	wrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	wrp_back #(
		.BATCH      (BATCH),
		.VOCAB      (VOCAB),
		.WINDOW_MAX (WINDOW_MAX),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.logit_out  (logit_out),
		.status     (status)
	);

endmodule
`default_nettype wire

// ===== test/windowed_repetition_penalty_check.sv =====
// ----------------------------------------------------------------------------
// windowed_repetition_penalty_check
// watches the item, result and register channels, keeps its own copy of the
// windowed token counts and penalty settings, predicts each result beat and
// compares it field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module windowed_repetition_penalty_check import wrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               kind,
	input  logic [1:0]         stream,
	input  logic [11:0]        token,
	input  logic               end_of_step,
	input  logic signed [15:0] logit_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] logit_out,
	input  logic               status,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	localparam int NB = 4;
	localparam int NV = 4096;
	localparam int NW = 256;
	localparam int CMAX = 65535;

	typedef struct {
		logic signed [15:0] logit;
		logic               status;
	} penalised_t;

	int unsigned tally [NB][NV];
	int unsigned recent [NB][NW];
	bit          recent_used [NB][NW];
	int unsigned slot_ptr;
	int unsigned win_len, vocab_lim, factor;
	logic signed [15:0] presence, frequency;
	penalised_t  expected_q [$];

	assign pending = expected_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint scaled(input longint x);
		longint unsigned m;
		if (factor <= 4096)
			return x;
		if (x > 0) begin
			m = x;
			return (m * 8192 + factor) / (2 * factor);
		end
		m = -x;
		return -longint'((m * factor + 2048) >> 12);
	endfunction

	function automatic penalised_t penalise(input logic k, input int unsigned s,
			input int unsigned t, input logic eos, input logic signed [15:0] x);
		penalised_t r;
		longint v;
		int unsigned lim, w, sl, old;
		lim = vocab_lim < NV ? vocab_lim : NV;
		r.status = (t >= lim);
		r.logit = 0;
		if (k == KIND_ADJUST) begin
			r.logit = x;
			if (r.status || tally[s][t] == 0)
				return r;
			v = scaled(x) - (longint'(presence) + longint'(tally[s][t]) * longint'(frequency));
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			r.logit = v[15:0];
			return r;
		end
		if (r.status)
			return r;
		if (tally[s][t] < CMAX)
			tally[s][t]++;
		w = win_len > NW ? NW : win_len;
		if (w > 0) begin
			sl = slot_ptr < w ? slot_ptr : 0;
			if (recent_used[s][sl]) begin
				old = recent[s][sl];
				if (tally[s][old] > 0)
					tally[s][old]--;
			end
			recent[s][sl] = t;
			recent_used[s][sl] = 1;
			slot_ptr = eos ? ((sl + 1 >= w) ? 0 : sl + 1) : sl;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		penalised_t e;
		if (!arst_n) begin
			foreach (tally[i, j]) tally[i][j] = 0;
			foreach (recent_used[i, j]) begin
				recent_used[i][j] = 0;
				recent[i][j] = 0;
			end
			slot_ptr = 0;
			win_len = 0;
			vocab_lim = 4096;
			factor = 4096;
			presence = 0;
			frequency = 0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH:    win_len = cfg_data[8:0];
					CFG_VOCAB_IN_USE:     vocab_lim = cfg_data[12:0];
					CFG_REPEAT_FACTOR:    factor = cfg_data;
					CFG_PRESENCE_AMOUNT:  presence = cfg_data;
					CFG_FREQUENCY_AMOUNT: frequency = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (logit_out !== e.logit)
						report("logit_out", logit_out, e.logit);
					if (status !== e.status)
						report("status", status, e.status);
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(penalise(kind, stream, token, end_of_step, logit_in));
		end
	end

endmodule

// ===== test/windowed_repetition_penalty_test.sv =====
// ----------------------------------------------------------------------------
// windowed_repetition_penalty_test
// drives directed and random update and adjust beats through several register
// settings with random gaps and stalls, and gives the verdict from the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module windowed_repetition_penalty_test;
	import wrp_pkg::*;

	localparam int WATCHDOG = 60000;

	logic clk, arst_n;
	logic in_valid, in_ready, kind, end_of_step;
	logic [1:0] stream;
	logic [11:0] token;
	logic signed [15:0] logit_in, logit_out;
	logic out_valid, out_ready, status;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int errors, pending;
	int send_idle, recv_idle, hold_off, quiet;
	int unsigned vocab_now;
	logic [11:0] hot [8];

	windowed_repetition_penalty dut (.*);

	windowed_repetition_penalty_check checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// receiver stalls, with a long hold-off on request
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("windowed_repetition_penalty regression: fail");
			$finish;
		end
	end

	// valid stays up between beats with no gap; drain drops it
	task automatic send(input logic k, input logic [1:0] s, input logic [11:0] t,
			input logic e, input logic signed [15:0] x);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		stream <= s;
		token <= t;
		end_of_step <= e;
		logit_in <= x;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_VOCAB_IN_USE)
			vocab_now = val[12:0];
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic settings(input int w, input int v, input int f, input int p, input int q);
		drain();
		write_reg(CFG_WINDOW_LENGTH, 16'(w));
		write_reg(CFG_VOCAB_IN_USE, 16'(v));
		write_reg(CFG_REPEAT_FACTOR, 16'(f));
		write_reg(CFG_PRESENCE_AMOUNT, 16'(p));
		write_reg(CFG_FREQUENCY_AMOUNT, 16'(q));
		cfg_valid <= 0;
	endtask

	task automatic random_items(input int n);
		logic [11:0] t;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: t = 12'($urandom);
				1: t = vocab_now > 4095 ? 12'(4095) : 12'(vocab_now + $urandom_range(1));
				default: t = hot[$urandom_range(7)];
			endcase
			send(1'($urandom_range(1)), 2'($urandom), t, $urandom_range(2) == 0,
				16'($urandom));
			foreach (hot[j])
				if ($urandom_range(40) == 0)
					hot[j] = 12'($urandom_range(vocab_now > 1 ? vocab_now - 1 : 0));
		end
	endtask

	initial begin
		in_valid = 0; kind = 0; stream = 0; token = 0; end_of_step = 0; logit_in = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		send_idle = 37; recv_idle = 73; hold_off = 0; quiet = 0; vocab_now = 4096;
		foreach (hot[j]) hot[j] = 12'($urandom_range(15));
		wait (arst_n);
		@(posedge clk);

		// defaults: no window, penalty 1.0
		send(KIND_ADJUST, 0, 0, 0, 16'sh7fff);
		send(KIND_UPDATE, 0, 0, 1, 0);
		send(KIND_UPDATE, 3, 12'hfff, 1, 0);
		send(KIND_ADJUST, 0, 0, 0, 16'sh7fff);
		send(KIND_ADJUST, 3, 12'hfff, 0, -16'sd32768);

		settings(2, 100, 16'hffff, 16'sh7fff, -16'sd32768);
		send(KIND_UPDATE, 1, 99, 0, 0);
		send(KIND_UPDATE, 1, 100, 1, 0);
		send(KIND_UPDATE, 1, 12'hfff, 1, 0);
		send(KIND_ADJUST, 1, 99, 0, 16'sh7fff);
		send(KIND_ADJUST, 1, 99, 0, -16'sd32768);
		send(KIND_ADJUST, 1, 99, 0, 1);
		send(KIND_ADJUST, 1, 99, 0, 0);
		send(KIND_ADJUST, 1, 100, 0, 5);
		send(KIND_UPDATE, 1, 7, 1, 0);
		send(KIND_UPDATE, 1, 8, 1, 0);
		send(KIND_ADJUST, 1, 99, 0, 300);
		send(KIND_UPDATE, 2, 5, 1, 0);

		// shortened window leaves the slot beyond it
		settings(1, 1, 4097, -16'sd32768, 16'sh7fff);
		send(KIND_UPDATE, 2, 0, 1, 0);
		send(KIND_ADJUST, 2, 0, 0, -16'sd5);
		send(KIND_UPDATE, 2, 1, 1, 0);

		settings(0, 4096, 6144, 16'sd64, 16'sd32);
		random_items(150);
		settings(256, 16, 8192, -16'sd16, 16'sd100);
		random_items(150);

		send_idle = 73; recv_idle = 37;
		settings(300, 4095, 4096, 16'sd256, -16'sd3);
		random_items(150);
		settings(5, 8, 0, 16'sd0, 16'sd200);
		random_items(100);

		send_idle = 0; recv_idle = 0;
		hold_off = 400;
		random_items(50);
		settings(3, 4000, 12345, 16'sd1000, 16'sd1000);
		random_items(150);
		settings(256, 4096, 65535, 16'sd0, -16'sd1);
		random_items(100);

		drain();
		if (errors == 0)
			$display("windowed_repetition_penalty regression: pass");
		else
			$display("windowed_repetition_penalty regression: fail");
		$finish;
	end

endmodule
